@@ hw/rtl/stream_byte_reassembler_defines.svh @@
// ----------------------------------------------------------------------------
// stream_byte_reassembler_defines: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STREAM_BYTE_REASSEMBLER_DEFINES_SVH
`define STREAM_BYTE_REASSEMBLER_DEFINES_SVH

// same-cycle implication
`define SBR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stream_byte_reassembler: same-cycle check failed");

// next-cycle implication
`define SBR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stream_byte_reassembler: next-cycle check failed");

`endif

@@ hw/rtl/sbr_pkg.sv @@
// ----------------------------------------------------------------------------
// sbr_pkg: shared types of the stream byte reassembler
// Command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbr_pkg;

	typedef struct packed {
		logic take;
		logic scan_adv;
		logic finish;
		logic close;
		logic emit_byte;
		logic emit_status;
	} sbr_cmd_t;

	typedef struct packed {
		logic scan_hit;
		logic cnt_zero;
		logic cnt_one;
		logic out_free;
	} sbr_sts_t;

endpackage

@@ hw/rtl/sbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbr_ctrl: reassembler sequencer
// Accept requests, scan the in-order run, settle status, emit results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbr_ctrl
	import sbr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     segment_last,
	input  sbr_sts_t sts,
	output logic     item_stall,
	output sbr_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_FINISH = 3'd2;
	localparam logic [2:0] ST_CLOSE  = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.take   = item_valid;
				if (item_valid && segment_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_hit) begin
					cmd.scan_adv = 1'b1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_CLOSE;
			end
			ST_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					if (sts.cnt_zero) begin
						cmd.emit_status = 1'b1;
						state_d         = ST_IDLE;
					end else begin
						cmd.emit_byte = 1'b1;
						if (sts.cnt_one) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/sbr_datapath.sv @@
// ----------------------------------------------------------------------------
// sbr_datapath: reassembler storage and result register
// Ring store with present bits, window and stream-end tracking, output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbr_datapath
	import sbr_pkg::*;
#(
	parameter int WINDOW_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  sbr_cmd_t    cmd,
	output sbr_sts_t    sts,
	input  logic [63:0] stream_index,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        segment_first,
	input  logic        segment_last,
	input  logic        final_segment,
	input  logic [6:0]  sink_room,
	input  logic        result_stall,
	output logic        result_valid,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        run_last,
	output logic        stream_closed,
	output logic [6:0]  bytes_pending
);

	localparam int              SLOT_W = $clog2(WINDOW_BYTES);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_BYTES - 1);
	localparam logic [SLOT_W:0]   WIN_S = (SLOT_W + 1)'(WINDOW_BYTES);
	localparam logic [6:0]        WIN_7 = 7'(WINDOW_BYTES);
	localparam logic [63:0]       WIN_64 = 64'(WINDOW_BYTES);

	logic [7:0]        mem [WINDOW_BYTES];
	logic [7:0]        rd_data_q;
	logic [WINDOW_BYTES-1:0] present_q;

	logic [63:0]       next_index_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic [63:0]       window_limit_q;
	logic              end_known_q;
	logic [63:0]       end_index_q;
	logic              closed_q;
	logic [6:0]        pending_q;
	logic [6:0]        cnt_q;
	logic [SLOT_W-1:0] scan_slot_q;

	logic              res_valid_q;
	logic [7:0]        res_byte_q;
	logic              res_has_q;
	logic              res_last_q;
	logic              res_closed_q;
	logic [6:0]        res_pending_q;

	logic [6:0]        room_sat;
	logic [63:0]       off;
	logic [63:0]       lim;
	logic              in_win;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] wr_slot;
	logic              store;
	logic [SLOT_W-1:0] rd_addr;
	logic              out_free;
	logic              load;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		slot_inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
	endfunction

	assign room_sat = (sink_room > WIN_7) ? WIN_7 : sink_room;
	assign off      = stream_index - next_index_q;
	assign lim      = segment_first ? {57'd0, room_sat} : window_limit_q - next_index_q;
	assign in_win   = (off < lim) && (off < WIN_64);
	assign slot_sum = {1'b0, next_slot_q} + off[SLOT_W:0];
	assign wr_slot  = (slot_sum >= WIN_S) ? SLOT_W'(slot_sum - WIN_S) : SLOT_W'(slot_sum);
	assign store    = cmd.take && has_byte && in_win && !present_q[wr_slot];
	assign rd_addr  = cmd.emit_byte ? slot_inc(next_slot_q) : next_slot_q;
	assign out_free = !res_valid_q || !result_stall;
	assign load     = cmd.emit_byte || cmd.emit_status;

	assign sts.scan_hit = present_q[scan_slot_q] && (cnt_q < WIN_7);
	assign sts.cnt_zero = (cnt_q == 7'd0);
	assign sts.cnt_one  = (cnt_q == 7'd1);
	assign sts.out_free = out_free;

	always_ff @(posedge clk) begin
		if (store) begin
			mem[wr_slot] <= data_byte;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q      <= '0;
			next_index_q   <= '0;
			next_slot_q    <= '0;
			window_limit_q <= '0;
			end_known_q    <= 1'b0;
			end_index_q    <= '0;
			closed_q       <= 1'b0;
			pending_q      <= '0;
			cnt_q          <= '0;
			scan_slot_q    <= '0;
		end else begin
			if (cmd.take) begin
				if (segment_first) begin
					window_limit_q <= next_index_q + {57'd0, room_sat};
				end
				if (store) begin
					present_q[wr_slot] <= 1'b1;
					if (pending_q < WIN_7) begin
						pending_q <= pending_q + 7'd1;
					end
				end
				if (segment_last && final_segment) begin
					end_known_q <= 1'b1;
					end_index_q <= stream_index + {63'd0, has_byte};
				end
				cnt_q       <= '0;
				scan_slot_q <= next_slot_q;
			end
			if (cmd.scan_adv) begin
				cnt_q       <= cnt_q + 7'd1;
				scan_slot_q <= slot_inc(scan_slot_q);
			end
			if (cmd.finish) begin
				next_index_q <= next_index_q + {57'd0, cnt_q};
				pending_q    <= (cnt_q > pending_q) ? 7'd0 : pending_q - cnt_q;
			end
			if (cmd.close && end_known_q && (next_index_q >= end_index_q)) begin
				closed_q <= 1'b1;
			end
			if (cmd.emit_byte) begin
				present_q[next_slot_q] <= 1'b0;
				next_slot_q            <= slot_inc(next_slot_q);
				cnt_q                  <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_byte_q    <= cmd.emit_byte ? rd_data_q : 8'd0;
			res_has_q     <= cmd.emit_byte;
			res_last_q    <= cmd.emit_status || (cnt_q == 7'd1);
			res_closed_q  <= closed_q;
			res_pending_q <= pending_q;
		end
	end

	assign result_valid  = res_valid_q;
	assign out_byte      = res_byte_q;
	assign out_valid     = res_has_q;
	assign run_last      = res_last_q;
	assign stream_closed = res_closed_q;
	assign bytes_pending = res_pending_q;

endmodule

@@ hw/rtl/stream_byte_reassembler.sv @@
// ----------------------------------------------------------------------------
// stream_byte_reassembler: out-of-order byte stream reassembly, one byte a request
// A non-last request does not stall the input; a last request holds it through the run scan
// (n = in-order run, scanned one present bit a cycle), finish, close and max(n,1) emits.
// Results leave at one a cycle through the single read port while result_stall is low.
// Reset clears present bits and state at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stream_byte_reassembler_defines.svh"

module stream_byte_reassembler
	import sbr_pkg::*;
#(
	parameter int WINDOW_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [63:0] stream_index,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        segment_first,
	input  logic        segment_last,
	input  logic        final_segment,
	input  logic [6:0]  sink_room,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        run_last,
	output logic        stream_closed,
	output logic [6:0]  bytes_pending
);

	sbr_cmd_t cmd;
	sbr_sts_t sts;

	sbr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.segment_last (segment_last),
		.sts          (sts),
		.item_stall   (item_stall),
		.cmd          (cmd)
	);

	sbr_datapath #(
		.WINDOW_BYTES (WINDOW_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.stream_index  (stream_index),
		.data_byte     (data_byte),
		.has_byte      (has_byte),
		.segment_first (segment_first),
		.segment_last  (segment_last),
		.final_segment (final_segment),
		.sink_room     (sink_room),
		.result_stall  (result_stall),
		.result_valid  (result_valid),
		.out_byte      (out_byte),
		.out_valid     (out_valid),
		.run_last      (run_last),
		.stream_closed (stream_closed),
		.bytes_pending (bytes_pending)
	);

	`SBR_ASSERT_NEXT(a_hold_after_last, item_valid && !item_stall && segment_last, item_stall)
	`SBR_ASSERT_NOW(a_status_is_last, result_valid && !out_valid, run_last)
	`SBR_ASSERT_NOW(a_pending_bound, result_valid, bytes_pending <= 7'(WINDOW_BYTES))

endmodule
